FILE: rtl/core/mcms_pkg.sv
// Shared types and constants for the masked column mean / std unit.
// No dependencies.
`timescale 1ns / 1ps

package mcms_pkg;

    localparam int unsigned DEF_MAX_ROWS = 4096;
    localparam int unsigned SAMPLE_W     = 16;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_NQ,
        BK_MUL_SS,
        BK_SQRT,
        BK_DIV_MEAN,
        BK_DIV_STD,
        BK_OUT
    } back_state_t;

    // Handshake between a producer and a consumer
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

FILE: rtl/core/mcms_front.sv
// Front end: per-sample accumulation, column minimum and mask register.
// Depends on mcms_pkg.
`timescale 1ns / 1ps

module mcms_front #(
    parameter int unsigned MAX_ROWS = mcms_pkg::DEF_MAX_ROWS,
    localparam int unsigned CW = $clog2(MAX_ROWS + 1),
    localparam int unsigned SW = CW + 17,
    localparam int unsigned QW = CW + 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [15:0]   sample,
    input  logic                 last_in_column,
    output mcms_pkg::hs_t        push,
    input  logic                 push_ready,
    output logic [SW+QW+CW-1:0]  push_data
);

    logic signed [15:0]   mask_reg;
    logic signed [SW-1:0] sum_all_reg, sum_all_next, sum_kept_reg, sum_kept_next;
    logic [QW-1:0]        sq_all_reg, sq_all_next, sq_kept_reg, sq_kept_next;
    logic [CW-1:0]        cnt_all_reg, cnt_all_next, cnt_kept_reg, cnt_kept_next;
    logic signed [15:0]   min_reg, min_next;
    logic                 accept;
    logic [31:0]          sq;
    logic signed [31:0]   prod;
    logic                 room;

    assign cfg_ready = 1'b1;
    assign in_stall  = !push_ready;
    assign accept    = in_valid && !in_stall;
    assign prod      = sample * sample;
    assign sq        = prod;
    assign room      = cnt_all_reg < CW'(MAX_ROWS);

    always_comb
    begin
        sum_all_next  = sum_all_reg;
        sum_kept_next = sum_kept_reg;
        sq_all_next   = sq_all_reg;
        sq_kept_next  = sq_kept_reg;
        cnt_all_next  = cnt_all_reg;
        cnt_kept_next = cnt_kept_reg;
        min_next      = min_reg;
        if (room)
        begin
            sum_all_next = sum_all_reg + SW'(sample);
            sq_all_next  = sq_all_reg + QW'(sq);
            cnt_all_next = cnt_all_reg + CW'(1);
            if (sample != mask_reg)
            begin
                sum_kept_next = sum_kept_reg + SW'(sample);
                sq_kept_next  = sq_kept_reg + QW'(sq);
                cnt_kept_next = cnt_kept_reg + CW'(1);
            end
            if (sample < min_reg)
                min_next = sample;
        end
    end

    // On the last beat the totals of the chosen set go to the queue
    assign push.valid = accept && last_in_column;
    assign push.ready = push_ready;
    assign push_data  = (min_next == mask_reg)
                      ? {sum_kept_next, sq_kept_next, cnt_kept_next}
                      : {sum_all_next, sq_all_next, cnt_all_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            sum_all_reg  <= '0;
            sum_kept_reg <= '0;
            sq_all_reg   <= '0;
            sq_kept_reg  <= '0;
            cnt_all_reg  <= '0;
            cnt_kept_reg <= '0;
            min_reg      <= 16'sh7FFF;
        end
        else
        begin
            if (cfg_valid)
                mask_reg <= cfg_data;
            if (accept)
            begin
                if (last_in_column)
                begin
                    sum_all_reg  <= '0;
                    sum_kept_reg <= '0;
                    sq_all_reg   <= '0;
                    sq_kept_reg  <= '0;
                    cnt_all_reg  <= '0;
                    cnt_kept_reg <= '0;
                    min_reg      <= 16'sh7FFF;
                end
                else
                begin
                    sum_all_reg  <= sum_all_next;
                    sum_kept_reg <= sum_kept_next;
                    sq_all_reg   <= sq_all_next;
                    sq_kept_reg  <= sq_kept_next;
                    cnt_all_reg  <= cnt_all_next;
                    cnt_kept_reg <= cnt_kept_next;
                    min_reg      <= min_next;
                end
            end
        end
    end

endmodule

FILE: rtl/core/mcms_queue.sv
// Two-entry queue of column totals between front and back end.
// Depends on mcms_pkg.
`timescale 1ns / 1ps

module mcms_queue #(
    parameter int unsigned W = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mcms_pkg::hs_t push,
    output logic          push_ready,
    input  logic [W-1:0]  push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [W-1:0]  pop_data
);

    logic [W-1:0] mem [2];
    logic         wr_reg, rd_reg;
    logic [1:0]   fill_reg;
    logic         do_push, do_pop;

    assign push_ready = fill_reg != 2'd2;
    assign pop_valid  = fill_reg != 2'd0;
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_reg <= !wr_reg;
            if (do_pop)
                rd_reg <= !rd_reg;
            fill_reg <= fill_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: rtl/core/mcms_back.sv
// Back end: shift-add multiply, digit-by-digit square root and restoring
// divide over many cycles, then the output register. Depends on mcms_pkg.
`timescale 1ns / 1ps

module mcms_back #(
    parameter int unsigned MAX_ROWS = mcms_pkg::DEF_MAX_ROWS,
    localparam int unsigned CW = $clog2(MAX_ROWS + 1),
    localparam int unsigned SW = CW + 17,
    localparam int unsigned QW = CW + 31,
    localparam int unsigned DW = QW + CW,
    localparam int unsigned RW = (DW + 1) / 2,
    localparam int unsigned NW = $clog2(SW + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [SW+QW+CW-1:0]  pop_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   column_mean,
    output logic [15:0]          column_std,
    output logic                 column_empty
);

    mcms_pkg::back_state_t state_reg, state_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    logic signed [SW-1:0] s_in;
    logic [QW-1:0]   q_in;
    logic [CW-1:0]   n_in;

    logic [SW-1:0]   s_abs_reg, s_abs_next;
    logic            s_neg_reg, s_neg_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [DW-1:0]   mcand_reg, mcand_next, acc_reg, acc_next;
    logic [SW-1:0]   mplier_reg, mplier_next;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [SW-1:0]   dvd_reg, dvd_next;
    logic [CW-1:0]   drem_reg, drem_next;
    logic [15:0]     mean_reg, mean_next, std_reg, std_next;
    logic            empty_reg, empty_next;
    logic            load_out;

    logic [RW+3:0]   sq_t, sq_trial;
    logic [CW:0]     dv_t;
    logic            dv_ge;

    assign {s_in, q_in, n_in} = pop_data;

    // One square-root digit and one divide bit per cycle
    assign sq_t     = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign dv_t     = {drem_reg, dvd_reg[SW-1]};
    assign dv_ge    = dv_t >= {1'b0, n_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        s_abs_next     = s_abs_reg;
        s_neg_next     = s_neg_reg;
        n_next         = n_reg;
        mcand_next     = mcand_reg;
        acc_next       = acc_reg;
        mplier_next    = mplier_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        drem_next      = drem_reg;
        mean_next      = mean_reg;
        std_next       = std_reg;
        empty_next     = empty_reg;
        pop_ready      = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            mcms_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    s_neg_next  = s_in[SW-1];
                    s_abs_next  = s_in[SW-1] ? SW'(-s_in) : SW'(s_in);
                    n_next      = n_in;
                    mcand_next  = DW'(q_in);
                    mplier_next = SW'(n_in);
                    acc_next    = '0;
                    cnt_next    = NW'(CW);
                    if (n_in == '0)
                    begin
                        mean_next  = '0;
                        std_next   = '0;
                        empty_next = 1'b1;
                        state_next = mcms_pkg::BK_OUT;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        state_next = mcms_pkg::BK_MUL_NQ;
                    end
                end
            end
            mcms_pkg::BK_MUL_NQ:
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    mcand_next  = DW'(s_abs_reg);
                    mplier_next = s_abs_reg;
                    cnt_next    = NW'(SW);
                    state_next  = mcms_pkg::BK_MUL_SS;
                end
            end
            mcms_pkg::BK_MUL_SS:
            begin
                // n*Q minus S*S, subtracting partial products of S*S
                if (mplier_reg[0])
                    acc_next = acc_reg - mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    rad_next   = (2*RW)'(acc_next);
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = NW'(RW);
                    state_next = mcms_pkg::BK_SQRT;
                end
            end
            mcms_pkg::BK_SQRT:
            begin
                rad_next = rad_reg << 2;
                if (sq_t >= sq_trial)
                begin
                    rem_next  = (RW+2)'(sq_t - sq_trial);
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = (RW+2)'(sq_t);
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    dvd_next   = s_abs_reg;
                    drem_next  = '0;
                    cnt_next   = NW'(SW);
                    state_next = mcms_pkg::BK_DIV_MEAN;
                end
            end
            mcms_pkg::BK_DIV_MEAN, mcms_pkg::BK_DIV_STD:
            begin
                drem_next = dv_ge ? CW'(dv_t - {1'b0, n_reg}) : CW'(dv_t);
                dvd_next  = {dvd_reg[SW-2:0], dv_ge};
                cnt_next  = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    if (state_reg == mcms_pkg::BK_DIV_MEAN)
                    begin
                        mean_next  = s_neg_reg ? 16'(-dvd_next[15:0]) : dvd_next[15:0];
                        dvd_next   = SW'(root_reg);
                        drem_next  = '0;
                        cnt_next   = NW'(SW);
                        state_next = mcms_pkg::BK_DIV_STD;
                    end
                    else
                    begin
                        std_next   = dvd_next[15:0];
                        state_next = mcms_pkg::BK_OUT;
                    end
                end
            end
            mcms_pkg::BK_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mcms_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mcms_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcms_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_abs_reg  <= s_abs_next;
        s_neg_reg  <= s_neg_next;
        n_reg      <= n_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        drem_reg   <= drem_next;
        mean_reg   <= mean_next;
        std_reg    <= std_next;
        empty_reg  <= empty_next;
        if (load_out)
        begin
            column_mean  <= mean_reg;
            column_std   <= std_reg;
            column_empty <= empty_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/masked_column_mean_std_unit.sv
// Top level of the masked column mean / standard deviation unit.
// Depends on mcms_pkg, mcms_front, mcms_queue, mcms_back.
`timescale 1ns / 1ps
//
//  channel | dir | handshake             | beat carries
//  --------+-----+-----------------------+----------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready | cfg_data: mask_value, signed Q8.8
//  in      | in  | in_valid / in_stall   | sample, last_in_column
//  out     | out | out_valid / out_stall | column_mean, column_std, column_empty
//
// Samples are taken one per cycle while in_stall is low; sums, squares, counts and
// the minimum are updated in the front end in the same cycle. The last beat of a
// column pushes the selected totals into a two-entry queue. The back end works
// through each column with a bit-serial multiplier, root and divider (SW = CW+17,
// CW = clog2(MAX_ROWS+1), RW = CW+16) and takes the next column only when idle.
// in_stall rises only while the queue is full.
// Reset is asynchronous, active low; mask_value resets to zero.
// Beyond MAX_ROWS samples a column's further samples are ignored.

module masked_column_mean_std_unit #(
    parameter int unsigned MAX_ROWS = mcms_pkg::DEF_MAX_ROWS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  sample,
    input  logic                last_in_column,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  column_mean,
    output logic [15:0]         column_std,
    output logic                column_empty
);

    localparam int unsigned CW = $clog2(MAX_ROWS + 1);
    localparam int unsigned TW = 3 * CW + 48;   // {sum, sum of squares, count}

    mcms_pkg::hs_t  push;
    logic           push_ready;
    logic [TW-1:0]  push_data;
    logic           pop_valid, pop_ready;
    logic [TW-1:0]  pop_data;

    // Per-sample accumulation
    mcms_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .last_in_column (last_in_column),
        .push           (push),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // Column totals waiting for the back end
    mcms_queue #(.W(TW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Mean and standard deviation per column
    mcms_back #(.MAX_ROWS(MAX_ROWS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column_mean  (column_mean),
        .column_std   (column_std),
        .column_empty (column_empty)
    );

    // An empty column reports zero mean and zero deviation
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && column_empty |-> column_mean == 16'sd0 && column_std == 16'd0)
        else $error("empty column with nonzero result");

    // A column end is never offered while the queue cannot take it
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> push_ready)
        else $error("column totals dropped");

    // Input is held off exactly when the queue is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !push_ready)
        else $error("input stalled with room in queue");

endmodule

FILE: verif/masked_column_mean_std_unit_tb.sv
// Self-checking testbench for masked_column_mean_std_unit: directed table, then
// random columns under several idle/stall mixes and mask settings.
// Depends on mcms_pkg and the unit RTL only.
`timescale 1ns / 1ps

module masked_column_mean_std_unit_tb;

    localparam int unsigned ROWS_CAP    = mcms_pkg::DEF_MAX_ROWS;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_WAIT  = 300;   // settling time for the back end after the last result

    typedef struct {
        logic signed [15:0] mean;
        logic [15:0]        std;
        logic               empty;
    } col_stats_t;

    // one row of the directed table; typed rows carry the expected stats
    typedef struct {
        logic signed [15:0] smp;
        logic               last;
        bit                 typed;
        logic signed [15:0] mean;
        logic [15:0]        std;
        logic               empty;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample;
    logic               last_in_column;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] column_mean;
    logic [15:0]        column_std;
    logic               column_empty;

    masked_column_mean_std_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .last_in_column (last_in_column),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .column_mean    (column_mean),
        .column_std     (column_std),
        .column_empty   (column_empty)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the column accumulators
    // ------------------------------------------------------------------
    logic signed [15:0] mask_shadow;
    longint             acc_sum_all, acc_sum_kept;
    longint unsigned    acc_sq_all, acc_sq_kept, acc_n_all, acc_n_kept;
    longint             acc_min;

    col_stats_t         pending_stats[$];
    int                 errors;
    int                 beats_sent, columns_checked, empty_seen, masked_seen;
    int unsigned        cycles;
    int                 idle_pct, stall_pct;

    function automatic void clear_accumulators();
        acc_sum_all  = 0;
        acc_sum_kept = 0;
        acc_sq_all   = 0;
        acc_sq_kept  = 0;
        acc_n_all    = 0;
        acc_n_kept   = 0;
        acc_min      = 32767;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Fold one accepted beat into the accumulators; on column end queue the stats.
    function automatic void accumulate_beat(dir_row_t row);
        longint          x, s, m;
        longint unsigned q, n, s_abs, sq;
        col_stats_t      st;
        x = row.smp;
        if (acc_n_all < ROWS_CAP)
        begin
            sq = longint'(x * x);
            acc_sum_all += x;
            acc_sq_all  += sq;
            acc_n_all++;
            if (row.smp != mask_shadow)
            begin
                acc_sum_kept += x;
                acc_sq_kept  += sq;
                acc_n_kept++;
            end
            if (x < acc_min)
                acc_min = x;
        end
        if (!row.last)
            return;
        // minimum hitting the mask value selects the kept-only totals
        if (acc_min == longint'(mask_shadow))
        begin
            s = acc_sum_kept;
            q = acc_sq_kept;
            n = acc_n_kept;
            masked_seen++;
        end
        else
        begin
            s = acc_sum_all;
            q = acc_sq_all;
            n = acc_n_all;
        end
        st.mean  = '0;
        st.std   = '0;
        st.empty = 1'b0;
        if (n == 0)
        begin
            st.empty = 1'b1;
            empty_seen++;
        end
        else
        begin
            m       = s / longint'(n);
            s_abs   = (s < 0) ? longint'(-s) : longint'(s);
            st.mean = m[15:0];
            st.std  = 16'(floor_root(n * q - s_abs * s_abs) / n);
        end
        if (row.typed)
        begin
            st.mean  = row.mean;
            st.std   = row.std;
            st.empty = row.empty;
        end
        pending_stats = {pending_stats, st};
        clear_accumulators();
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_beat(dir_row_t row);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        sample         <= row.smp;
        last_in_column <= row.last;
        do
            @(posedge clk);
        while (in_stall);
        accumulate_beat(row);
        beats_sent++;
    endtask

    task automatic send_plain(logic signed [15:0] s, logic l);
        dir_row_t row;
        row       = '{s, l, 1'b0, '0, '0, 1'b0};
        send_beat(row);
    endtask

    // Wait until every column result is back, then let the back end settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_mask(logic signed [15:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        mask_shadow = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random column; shape decides how the mask gets exercised.
    task automatic random_column(output int len);
        int shape, v, k;
        shape = $urandom_range(3);
        len   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (k = 0; k < len; k++)
        begin
            case (shape)
                0: v = $signed(16'($urandom));
                1:  // values at or above the mask, with some at the mask
                    v = ($urandom_range(2) == 0) ? int'(mask_shadow)
                        : int'(mask_shadow) + $urandom_range(32767 - int'(mask_shadow));
                2: v = ($urandom_range(7) == 0) ? int'(mask_shadow) + 1 : int'(mask_shadow);
                default: v = $urandom_range(512) - 256;
            endcase
            if (v > 32767)
                v = 32767;
            send_plain(16'(v), k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected result mean=%0d std=%0d empty=%0b",
                         $time, column_mean, column_std, column_empty);
                errors++;
            end
            else
            begin
                col_stats_t st;
                st = pending_stats.pop_front();
                if (column_mean !== st.mean)
                begin
                    $display("%0t: mean expected %0d got %0d", $time, st.mean, column_mean);
                    errors++;
                end
                if (column_std !== st.std)
                begin
                    $display("%0t: std expected %0d got %0d", $time, st.std, column_std);
                    errors++;
                end
                if (column_empty !== st.empty)
                begin
                    $display("%0t: empty expected %0b got %0b", $time, st.empty,
                             column_empty);
                    errors++;
                end
                columns_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table (mask at reset value 0)
    // ------------------------------------------------------------------
    dir_row_t dir_rows[] = '{
        '{16'sd32767,  1'b1, 1'b1, 16'sd32767, 16'd0,     1'b0},  // lone max
        '{-16'sd32768, 1'b1, 1'b1, -16'sd32768, 16'd0,    1'b0},  // lone min
        '{16'sd0,      1'b1, 1'b1, 16'sd0,     16'd0,     1'b1},  // lone masked -> empty
        '{-16'sd32768, 1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd32767,  1'b1, 1'b1, 16'sd0,     16'd32767, 1'b0},  // widest spread
        '{16'sd512,    1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd0,      1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd256,    1'b1, 1'b0, 16'sd0,     16'd0,     1'b0},  // min at mask
        '{-16'sd1,     1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd0,      1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd1,      1'b1, 1'b0, 16'sd0,     16'd0,     1'b0},  // mask not the min
        '{16'sd0,      1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd0,      1'b1, 1'b1, 16'sd0,     16'd0,     1'b1},  // all masked
        '{-16'sd7,     1'b0, 1'b0, 16'sd0,     16'd0,     1'b0},
        '{16'sd3,      1'b1, 1'b0, 16'sd0,     16'd0,     1'b0}   // negative mean
    };

    logic signed [15:0] mask_plan[] = '{16'sd0, -16'sd32768, 16'sd32767, -16'sd256, 16'sd0};
    int idle_plan[]  = '{0, 53, 0, 22, 0};
    int stall_plan[] = '{0, 0, 53, 22, 0};

    initial
    begin
        int p, len, phase_beats;
        errors          = 0;
        beats_sent      = 0;
        columns_checked = 0;
        empty_seen      = 0;
        masked_seen     = 0;
        cycles          = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        mask_shadow     = '0;
        clear_accumulators();
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        sample         = '0;
        last_in_column = 1'b0;
        out_stall      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i]);

        for (p = 0; p < mask_plan.size(); p++)
        begin
            idle_pct  = 0;
            stall_pct = 0;
            write_mask((p == 4) ? 16'($urandom) : mask_plan[p]);
            idle_pct    = idle_plan[p];
            stall_pct   = stall_plan[p];
            phase_beats = 0;
            while (phase_beats < 200)
            begin
                random_column(len);
                phase_beats += len;
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain();
        $display("Sent %0d beats over %0d checked columns (%0d mask-selected, %0d empty),",
                 beats_sent, columns_checked, masked_seen, empty_seen);
        $display("five mask settings incl. both extremes, with idle and stall mixes.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
